FILE: sv/tpwl_pkg.sv
`timescale 1ns / 1ps
package tpwl_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int TIME_BITS_DEF  = 32;
    localparam int PRICE_BITS_DEF = 32;

    localparam int ADDR_BITS = 3;

    localparam logic [ADDR_BITS-1:0] REG_WINDOW    = 3'd0;
    localparam logic [ADDR_BITS-1:0] REG_JUMP_GAP  = 3'd1;
    localparam logic [ADDR_BITS-1:0] REG_MAX_BP    = 3'd2;
    localparam logic [ADDR_BITS-1:0] REG_EVICT_TOL = 3'd3;
    localparam logic [ADDR_BITS-1:0] REG_STALE     = 3'd4;

    localparam logic [1:0] RJ_NONE  = 2'd0;
    localparam logic [1:0] RJ_ORDER = 2'd1;
    localparam logic [1:0] RJ_ZERO  = 2'd2;
    localparam logic [1:0] RJ_JUMP  = 2'd3;

    localparam logic [15:0] BP_SCALE = 16'd10000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_RD,
        ST_T_CHK,
        ST_T_MUL,
        ST_T_CMP,
        ST_T_WR,
        ST_EV_RD,
        ST_EV_CHK,
        ST_Q_RD,
        ST_Q_CHK,
        ST_Q_FIN,
        ST_NEW_RD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic rd_last;
        logic rd_oldest;
        logic rd_mid;
        logic rd_found;
        logic rd_newest;
        logic mul;
        logic write_tick;
        logic drop_oldest;
        logic set_ready;
        logic q_init;
        logic q_step;
        logic q_finish;
        logic reject;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic       is_query;
        logic       order_bad;
        logic       zero_price;
        logic       need_jump;
        logic       jump_bad;
        logic       evict_more;
        logic       q_empty;
        logic       q_searching;
    } stat_t;

endpackage

FILE: sv/tpwl_ram.sv
`timescale 1ns / 1ps
module tpwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/tpwl_ctrl.sv
`timescale 1ns / 1ps
module tpwl_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_busy,
    input  tpwl_pkg::stat_t stat,
    output tpwl_pkg::ctrl_t ctrl,
    output logic            idle
);

    tpwl_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpwl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        idle = 1'b0;
        unique case (state_reg)
            tpwl_pkg::ST_IDLE:
            begin
                idle = 1'b1;
                if (in_fire)
                begin
                    ctrl.load_in = 1'b1;
                    state_next = tpwl_pkg::ST_T_RD;
                end
            end
            tpwl_pkg::ST_T_RD:
            begin
                if (stat.is_query)
                begin
                    ctrl.q_init = 1'b1;
                    state_next = tpwl_pkg::ST_Q_RD;
                end
                else
                begin
                    ctrl.rd_last = 1'b1;
                    state_next = tpwl_pkg::ST_T_CHK;
                end
            end
            tpwl_pkg::ST_T_CHK:
            begin
                if (stat.order_bad || stat.zero_price)
                begin
                    ctrl.reject = 1'b1;
                    state_next = tpwl_pkg::ST_NEW_RD;
                end
                else if (stat.need_jump)
                begin
                    ctrl.mul = 1'b1;
                    state_next = tpwl_pkg::ST_T_MUL;
                end
                else
                begin
                    state_next = tpwl_pkg::ST_T_WR;
                end
            end
            tpwl_pkg::ST_T_MUL:
            begin
                state_next = tpwl_pkg::ST_T_CMP;
            end
            tpwl_pkg::ST_T_CMP:
            begin
                if (stat.jump_bad)
                begin
                    ctrl.reject = 1'b1;
                    state_next = tpwl_pkg::ST_NEW_RD;
                end
                else
                begin
                    state_next = tpwl_pkg::ST_T_WR;
                end
            end
            tpwl_pkg::ST_T_WR:
            begin
                ctrl.write_tick = 1'b1;
                state_next = tpwl_pkg::ST_EV_RD;
            end
            tpwl_pkg::ST_EV_RD:
            begin
                ctrl.rd_oldest = 1'b1;
                state_next = tpwl_pkg::ST_EV_CHK;
            end
            tpwl_pkg::ST_EV_CHK:
            begin
                if (stat.evict_more)
                begin
                    ctrl.drop_oldest = 1'b1;
                    state_next = tpwl_pkg::ST_EV_RD;
                end
                else
                begin
                    ctrl.set_ready = 1'b1;
                    state_next = tpwl_pkg::ST_NEW_RD;
                end
            end
            tpwl_pkg::ST_Q_RD:
            begin
                if (stat.q_empty || !stat.q_searching)
                begin
                    ctrl.rd_found = 1'b1;
                    state_next = tpwl_pkg::ST_Q_FIN;
                end
                else
                begin
                    ctrl.rd_mid = 1'b1;
                    state_next = tpwl_pkg::ST_Q_CHK;
                end
            end
            tpwl_pkg::ST_Q_CHK:
            begin
                ctrl.q_step = 1'b1;
                state_next = tpwl_pkg::ST_Q_RD;
            end
            tpwl_pkg::ST_Q_FIN:
            begin
                ctrl.q_finish = 1'b1;
                state_next = tpwl_pkg::ST_NEW_RD;
            end
            tpwl_pkg::ST_NEW_RD:
            begin
                ctrl.rd_newest = 1'b1;
                state_next = tpwl_pkg::ST_DONE;
            end
            tpwl_pkg::ST_DONE:
            begin
                // hold the newest-entry read while the result waits
                ctrl.rd_newest = 1'b1;
                if (!out_busy)
                begin
                    ctrl.out_load = 1'b1;
                    state_next = tpwl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tpwl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/tpwl_dp.sv
`timescale 1ns / 1ps
module tpwl_dp #(
    parameter int DEPTH      = tpwl_pkg::DEPTH_DEF,
    parameter int TIME_BITS  = tpwl_pkg::TIME_BITS_DEF,
    parameter int PRICE_BITS = tpwl_pkg::PRICE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tpwl_pkg::ctrl_t          ctrl,
    output tpwl_pkg::stat_t          stat,
    input  logic                     in_req_type,
    input  logic [TIME_BITS-1:0]     in_timestamp,
    input  logic [PRICE_BITS-1:0]    in_price,
    input  logic [TIME_BITS-1:0]     in_seconds_back,
    input  logic [31:0]              window_len,
    input  logic [15:0]              jump_gap_seconds,
    input  logic [13:0]              max_change_bp,
    input  logic [15:0]              evict_tolerance_seconds,
    input  logic [15:0]              max_staleness_seconds,
    output logic                     res_accepted,
    output logic [1:0]               res_reject_code,
    output logic                     res_window_ready,
    output logic                     res_lookback_found,
    output logic [PRICE_BITS-1:0]    res_lookback_price,
    output logic [PRICE_BITS-1:0]    res_latest_price,
    output logic [$clog2(DEPTH):0]   res_entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam int MW = PRICE_BITS + 16;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic                  req_type_reg;
    logic [TIME_BITS-1:0]  t_reg;
    logic [PRICE_BITS-1:0] p_reg;
    logic [TIME_BITS-1:0]  back_reg;
    logic [AW-1:0]         oldest_reg, oldest_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [TIME_BITS-1:0]  latest_time_reg, latest_time_next;
    logic                  ready_reg, ready_next;
    logic [CW-1:0]         lo_reg, lo_next;
    logic [CW-1:0]         hi_reg, hi_next;
    logic [TIME_BITS-1:0]  target_reg;
    logic                  q_bad_reg;
    logic [MW-1:0]         lhs_reg;
    logic [MW-1:0]         rhs_reg;
    logic                  found_reg;
    logic [PRICE_BITS-1:0] lprice_reg;
    logic [1:0]            code_reg;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    logic [TIME_BITS-1:0]  t_rd;
    logic [PRICE_BITS-1:0] p_rd;

    logic [CW-1:0]         mid;
    logic [CW-1:0]         rel;
    logic [CW:0]           abs_sum;
    logic [PRICE_BITS-1:0] diff;
    logic [TIME_BITS-1:0]  age;
    logic [TIME_BITS:0]    evict_lim;
    logic [CW-1:0]         cnt_eff;
    logic [AW-1:0]         old_eff;

    tpwl_ram #(.WIDTH(TIME_BITS), .DEPTH(DEPTH)) u_time (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (t_reg),
        .raddr (raddr),
        .rdata (t_rd)
    );

    tpwl_ram #(.WIDTH(PRICE_BITS), .DEPTH(DEPTH)) u_price (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (p_reg),
        .raddr (raddr),
        .rdata (p_rd)
    );

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // ring slot = (oldest + rel) mod DEPTH
    always_comb
    begin
        rel = mid;
        if (ctrl.rd_last || ctrl.rd_newest)
        begin
            rel = count_reg - CW'(1);
        end
        else if (ctrl.rd_found)
        begin
            rel = lo_reg - CW'(1);
        end
        else if (ctrl.rd_oldest)
        begin
            rel = '0;
        end
        abs_sum = {1'b0, CW'(oldest_reg)} + {1'b0, rel};
        if (abs_sum >= (CW + 1)'(DEPTH))
        begin
            abs_sum = abs_sum - (CW + 1)'(DEPTH);
        end
        raddr = abs_sum[AW-1:0];
    end

    assign cnt_eff = (count_reg >= DEPTH_C) ? count_reg - CW'(1) : count_reg;
    always_comb
    begin
        old_eff = oldest_reg;
        if (count_reg >= DEPTH_C)
        begin
            old_eff = (32'(oldest_reg) == DEPTH - 1) ? '0 : oldest_reg + AW'(1);
        end
    end

    always_comb
    begin
        logic [CW:0] s;
        s = {1'b0, CW'(old_eff)} + {1'b0, cnt_eff};
        if (s >= (CW + 1)'(DEPTH))
        begin
            s = s - (CW + 1)'(DEPTH);
        end
        waddr = s[AW-1:0];
    end

    assign we = ctrl.write_tick;
    assign diff = (p_reg >= p_rd) ? p_reg - p_rd : p_rd - p_reg;
    assign age = latest_time_reg - t_rd;
    assign evict_lim = {1'b0, TIME_BITS'(window_len)}
                     + (TIME_BITS + 1)'(evict_tolerance_seconds);

    always_comb
    begin
        stat.is_query    = req_type_reg;
        stat.order_bad   = t_reg < latest_time_reg;
        stat.zero_price  = p_reg == '0;
        stat.need_jump   = (count_reg != '0)
                         && ((t_reg - t_rd) < TIME_BITS'(jump_gap_seconds));
        stat.jump_bad    = lhs_reg > rhs_reg;
        stat.evict_more  = (count_reg > CW'(1)) && ({1'b0, age} > evict_lim);
        stat.q_empty     = q_bad_reg;
        stat.q_searching = lo_reg < hi_reg;
    end

    always_comb
    begin
        oldest_next      = oldest_reg;
        count_next       = count_reg;
        latest_time_next = latest_time_reg;
        ready_next       = ready_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        if (ctrl.write_tick)
        begin
            oldest_next      = old_eff;
            count_next       = cnt_eff + CW'(1);
            latest_time_next = t_reg;
        end
        if (ctrl.drop_oldest)
        begin
            oldest_next = (32'(oldest_reg) == DEPTH - 1) ? '0 : oldest_reg + AW'(1);
            count_next  = count_reg - CW'(1);
        end
        if (ctrl.set_ready)
        begin
            ready_next = age >= TIME_BITS'(window_len);
        end
        if (ctrl.q_init)
        begin
            lo_next = '0;
            hi_next = count_reg;
        end
        if (ctrl.q_step)
        begin
            if (t_rd <= target_reg)
            begin
                lo_next = mid + CW'(1);
            end
            else
            begin
                hi_next = mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg      <= '0;
            count_reg       <= '0;
            latest_time_reg <= '0;
            ready_reg       <= 1'b0;
        end
        else
        begin
            oldest_reg      <= oldest_next;
            count_reg       <= count_next;
            latest_time_reg <= latest_time_next;
            ready_reg       <= ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (ctrl.load_in)
        begin
            req_type_reg <= in_req_type;
            t_reg        <= in_timestamp;
            p_reg        <= in_price;
            back_reg     <= in_seconds_back;
            code_reg     <= tpwl_pkg::RJ_NONE;
            found_reg    <= 1'b0;
            lprice_reg   <= '0;
        end
        if (ctrl.q_init)
        begin
            target_reg <= latest_time_reg - back_reg;
            q_bad_reg  <= (count_reg == '0) || (back_reg > latest_time_reg);
        end
        if (ctrl.mul)
        begin
            lhs_reg <= MW'(diff) * MW'(tpwl_pkg::BP_SCALE);
            rhs_reg <= MW'(p_rd) * MW'(max_change_bp);
        end
        if (ctrl.reject)
        begin
            if (stat.order_bad)
            begin
                code_reg <= tpwl_pkg::RJ_ORDER;
            end
            else if (stat.zero_price)
            begin
                code_reg <= tpwl_pkg::RJ_ZERO;
            end
            else
            begin
                code_reg <= tpwl_pkg::RJ_JUMP;
            end
        end
        if (ctrl.q_finish)
        begin
            if (!q_bad_reg && lo_reg != '0
                && (target_reg - t_rd) <= TIME_BITS'(max_staleness_seconds))
            begin
                found_reg  <= 1'b1;
                lprice_reg <= p_rd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            res_accepted       <= !req_type_reg && (code_reg == tpwl_pkg::RJ_NONE);
            res_reject_code    <= code_reg;
            res_window_ready   <= ready_reg;
            res_lookback_found <= found_reg;
            res_lookback_price <= lprice_reg;
            res_latest_price   <= (count_reg == '0) ? '0 : p_rd;
            res_entry_count    <= count_reg;
        end
    end

endmodule

FILE: sv/timed_price_window_lookback_unit.sv
`timescale 1ns / 1ps
// channel  | direction | content
// s_axis   | in        | tdata: req_type, timestamp, price, seconds_back
// m_axis   | out       | tdata: accepted .. entry_count
// apb      | in        | five configuration registers at 4*i
// A query is a binary search over the stored entries, one RAM read per step.
// A tick is checked for order and zero price, and by the jump test when the last entry
// lies within the jump gap; a stored tick then evicts oldest entries older than the
// window plus the eviction tolerance, keeping at least one entry.
// One item at a time; a finished item holds its result until the result register is free.
// Reset clears ring pointers, count, latest time and ready flag; RAM contents are not cleared.
module timed_price_window_lookback_unit #(
    parameter int DEPTH      = tpwl_pkg::DEPTH_DEF,
    parameter int TIME_BITS  = tpwl_pkg::TIME_BITS_DEF,
    parameter int PRICE_BITS = tpwl_pkg::PRICE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // req_type, timestamp, price, seconds_back (low to high), zero fill
    input  logic [((1 + 2*TIME_BITS + PRICE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // accepted, reject_code, window_ready, lookback_found, lookback_price,
    // latest_price, entry_count (low to high), zero fill
    output logic [((5 + 2*PRICE_BITS + $clog2(DEPTH) + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [tpwl_pkg::ADDR_BITS+1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(DEPTH) + 1;
    localparam int OW = 5 + 2*PRICE_BITS + CW;
    localparam int OWP = ((OW + 7) / 8) * 8;

    logic [31:0] window_reg;
    logic [15:0] jump_gap_reg;
    logic [13:0] max_bp_reg;
    logic [15:0] evict_tol_reg;
    logic [15:0] stale_reg;
    logic        out_valid_reg;

    tpwl_pkg::ctrl_t ctrl;
    tpwl_pkg::stat_t stat;
    logic idle;
    logic in_fire;
    logic [tpwl_pkg::ADDR_BITS-1:0] reg_idx;

    logic                  r_acc;
    logic [1:0]            r_code;
    logic                  r_ready;
    logic                  r_found;
    logic [PRICE_BITS-1:0] r_lp;
    logic [PRICE_BITS-1:0] r_np;
    logic [CW-1:0]         r_cnt;

    assign pready = 1'b1;
    assign reg_idx = paddr[tpwl_pkg::ADDR_BITS+1:2];
    assign s_axis_tready = idle;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= 32'd3600;
            jump_gap_reg  <= 16'd120;
            max_bp_reg    <= 14'd150;
            evict_tol_reg <= 16'd300;
            stale_reg     <= 16'd300;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx)
                tpwl_pkg::REG_WINDOW:    window_reg    <= pwdata;
                tpwl_pkg::REG_JUMP_GAP:  jump_gap_reg  <= pwdata[15:0];
                tpwl_pkg::REG_MAX_BP:    max_bp_reg    <= pwdata[13:0];
                tpwl_pkg::REG_EVICT_TOL: evict_tol_reg <= pwdata[15:0];
                tpwl_pkg::REG_STALE:     stale_reg     <= pwdata[15:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            tpwl_pkg::REG_WINDOW:    prdata = window_reg;
            tpwl_pkg::REG_JUMP_GAP:  prdata = {16'd0, jump_gap_reg};
            tpwl_pkg::REG_MAX_BP:    prdata = {18'd0, max_bp_reg};
            tpwl_pkg::REG_EVICT_TOL: prdata = {16'd0, evict_tol_reg};
            tpwl_pkg::REG_STALE:     prdata = {16'd0, stale_reg};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = OWP'({r_cnt, r_np, r_lp, r_found, r_ready, r_code, r_acc});

    tpwl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (out_valid_reg && !m_axis_tready),
        .stat     (stat),
        .ctrl     (ctrl),
        .idle     (idle)
    );

    tpwl_dp #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS), .PRICE_BITS(PRICE_BITS)) u_dp (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .ctrl                    (ctrl),
        .stat                    (stat),
        .in_req_type             (s_axis_tdata[0]),
        .in_timestamp            (s_axis_tdata[TIME_BITS:1]),
        .in_price                (s_axis_tdata[TIME_BITS+PRICE_BITS:TIME_BITS+1]),
        .in_seconds_back         (s_axis_tdata[2*TIME_BITS+PRICE_BITS:TIME_BITS+PRICE_BITS+1]),
        .window_len              (window_reg),
        .jump_gap_seconds        (jump_gap_reg),
        .max_change_bp           (max_bp_reg),
        .evict_tolerance_seconds (evict_tol_reg),
        .max_staleness_seconds   (stale_reg),
        .res_accepted            (r_acc),
        .res_reject_code         (r_code),
        .res_window_ready        (r_ready),
        .res_lookback_found      (r_found),
        .res_lookback_price      (r_lp),
        .res_latest_price        (r_np),
        .res_entry_count         (r_cnt)
    );

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped under stall");
    a_busy_noaccept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("second word taken while busy");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> !(out_valid_reg && !m_axis_tready))
        else $error("result overwritten");

endmodule

FILE: tb/price_window_checker.sv
`timescale 1ns / 1ps
module price_window_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [79:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic         pready,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output int           fail_count,
    output int           pending,
    output int           result_count
);

    localparam int RING = 1024;
    localparam int EXP_DEPTH = 16;

    // entry_count in the highest bits down to accepted in bit 0
    typedef struct packed {
        bit [10:0] entry_count;
        bit [31:0] latest_price;
        bit [31:0] lookback_price;
        bit        lookback_found;
        bit        window_ready;
        bit [1:0]  reject_code;
        bit        accepted;
    } window_result_t;

    bit [31:0]   ring_time [RING];
    bit [31:0]   ring_price [RING];
    int unsigned head;
    int unsigned fill;
    bit [31:0]   newest_time;
    bit          ready;

    bit [31:0] window_len;
    bit [15:0] jump_gap;
    bit [13:0] change_bp;
    bit [15:0] evict_tol;
    bit [15:0] stale_limit;

    window_result_t exp_buf [EXP_DEPTH];
    int unsigned    exp_wr;
    int unsigned    exp_rd;
    int unsigned    exp_level;

    function automatic int unsigned ring_pos(int unsigned k);
        return (head + k) % RING;
    endfunction

    function automatic bit [1:0] store_tick(bit [31:0] t, bit [31:0] p);
        int unsigned last;
        bit [63:0]   diff;
        bit [31:0]   prev_p;
        if (t < newest_time)
            return tpwl_pkg::RJ_ORDER;
        if (p == 0)
            return tpwl_pkg::RJ_ZERO;
        if (fill > 0)
        begin
            last = ring_pos(fill - 1);
            prev_p = ring_price[last];
            if (t - ring_time[last] < 32'(jump_gap))
            begin
                diff = (p >= prev_p) ? 64'(p - prev_p) : 64'(prev_p - p);
                if (diff * 64'd10000 > 64'(change_bp) * 64'(prev_p))
                    return tpwl_pkg::RJ_JUMP;
            end
        end
        if (fill >= RING)
        begin
            head = ring_pos(1);
            fill--;
        end
        last = ring_pos(fill);
        ring_time[last] = t;
        ring_price[last] = p;
        fill++;
        newest_time = t;
        while (fill > 1 &&
               64'(newest_time - ring_time[head]) > 64'(window_len) + 64'(evict_tol))
        begin
            head = ring_pos(1);
            fill--;
        end
        ready = (newest_time - ring_time[head]) >= window_len;
        return tpwl_pkg::RJ_NONE;
    endfunction

    function automatic bit find_lookback(bit [31:0] back, output bit [31:0] px);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        bit [31:0]   target;
        px = 0;
        lo = 0;
        hi = fill;
        if (fill == 0 || back > newest_time)
            return 0;
        target = newest_time - back;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (ring_time[ring_pos(mid)] <= target)
                lo = mid + 1;
            else
                hi = mid;
        end
        if (lo == 0)
            return 0;
        if (target - ring_time[ring_pos(lo - 1)] > 32'(stale_limit))
            return 0;
        px = ring_price[ring_pos(lo - 1)];
        return 1;
    endfunction

    function automatic window_result_t predict_word(bit [103:0] w);
        window_result_t r;
        bit [31:0]      px;
        r = '0;
        if (w[0] == 1'b0)
        begin
            r.reject_code = store_tick(w[32:1], w[64:33]);
            r.accepted = (r.reject_code == tpwl_pkg::RJ_NONE);
        end
        else
        begin
            r.lookback_found = find_lookback(w[96:65], px);
            r.lookback_price = px;
        end
        r.window_ready = ready;
        r.latest_price = (fill > 0) ? ring_price[ring_pos(fill - 1)] : 32'd0;
        r.entry_count = 11'(fill);
        return r;
    endfunction

    task automatic store_expected(window_result_t r);
        if (exp_level == EXP_DEPTH)
        begin
            $display("%0t: too many words in flight", $time);
            fail_count++;
            return;
        end
        exp_buf[exp_wr] = r;
        exp_wr = (exp_wr + 1) % EXP_DEPTH;
        exp_level++;
    endtask

    task automatic compare_word(window_result_t got);
        window_result_t exp_r;
        if (exp_level == 0)
        begin
            $display("%0t: unexpected word %h", $time, got);
            fail_count++;
            return;
        end
        exp_r = exp_buf[exp_rd];
        exp_rd = (exp_rd + 1) % EXP_DEPTH;
        exp_level--;
        if (exp_r.accepted != got.accepted)
            $display("%0t: accepted exp %0d got %0d", $time, exp_r.accepted, got.accepted);
        if (exp_r.reject_code != got.reject_code)
            $display("%0t: reject_code exp %0d got %0d", $time, exp_r.reject_code,
                     got.reject_code);
        if (exp_r.window_ready != got.window_ready)
            $display("%0t: window_ready exp %0d got %0d", $time, exp_r.window_ready,
                     got.window_ready);
        if (exp_r.lookback_found != got.lookback_found)
            $display("%0t: lookback_found exp %0d got %0d", $time, exp_r.lookback_found,
                     got.lookback_found);
        if (exp_r.lookback_price != got.lookback_price)
            $display("%0t: lookback_price exp %0d got %0d", $time, exp_r.lookback_price,
                     got.lookback_price);
        if (exp_r.latest_price != got.latest_price)
            $display("%0t: latest_price exp %0d got %0d", $time, exp_r.latest_price,
                     got.latest_price);
        if (exp_r.entry_count != got.entry_count)
            $display("%0t: entry_count exp %0d got %0d", $time, exp_r.entry_count,
                     got.entry_count);
        if (exp_r != got)
            fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head = 0;
            fill = 0;
            newest_time = 0;
            ready = 0;
            window_len = 32'd3600;
            jump_gap = 16'd120;
            change_bp = 14'd150;
            evict_tol = 16'd300;
            stale_limit = 16'd300;
            exp_wr = 0;
            exp_rd = 0;
            exp_level = 0;
            fail_count = 0;
            pending <= 0;
            result_count <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                compare_word(m_axis_tdata);
                result_count <= result_count + 1;
            end
            if (s_axis_tvalid && s_axis_tready)
                store_expected(predict_word(s_axis_tdata));
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    tpwl_pkg::REG_WINDOW:    window_len = pwdata;
                    tpwl_pkg::REG_JUMP_GAP:  jump_gap = pwdata[15:0];
                    tpwl_pkg::REG_MAX_BP:    change_bp = pwdata[13:0];
                    tpwl_pkg::REG_EVICT_TOL: evict_tol = pwdata[15:0];
                    tpwl_pkg::REG_STALE:     stale_limit = pwdata[15:0];
                    default: ;
                endcase
            end
            pending <= int'(exp_level);
        end
    end

endmodule

FILE: tb/timed_price_window_lookback_unit_tb.sv
`timescale 1ns / 1ps
module timed_price_window_lookback_unit_tb;

    localparam int CYCLE_LIMIT = 2000000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // req_type, timestamp, price, seconds_back (low to high), zero fill
    logic [103:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // accepted, reject_code, window_ready, lookback_found, lookback_price,
    // latest_price, entry_count (low to high), zero fill
    logic [79:0]  m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    int fail_count;
    int pending;
    int result_count;
    int cycles;
    int words_sent;
    int send_idle;
    int recv_idle;
    bit [31:0] cur_ts;
    bit [31:0] cur_px;

    timed_price_window_lookback_unit dut (.*);

    price_window_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
        if (rst_n)
            m_axis_tready = ($urandom % 100) >= recv_idle;

    task automatic send_word(bit req, bit [31:0] ts, bit [31:0] px, bit [31:0] back);
        if (words_sent < 400)
        begin
            send_idle = 20;
            recv_idle = 61;
        end
        else if (words_sent < 800)
        begin
            send_idle = 61;
            recv_idle = 20;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
        while (($urandom % 100) < send_idle)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {7'd0, back, px, ts, req};
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic tick(bit [31:0] ts, bit [31:0] px);
        send_word(1'b0, ts, px, $urandom);
    endtask

    task automatic query(bit [31:0] back);
        send_word(1'b1, $urandom, $urandom, back);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending != 0 || (m_axis_tvalid === 1'b1))
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, bit [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_config(bit [31:0] win, bit [15:0] gap, bit [13:0] bp,
                              bit [15:0] tol, bit [15:0] stale);
        drain();
        write_reg(tpwl_pkg::REG_WINDOW, win);
        write_reg(tpwl_pkg::REG_JUMP_GAP, gap);
        write_reg(tpwl_pkg::REG_MAX_BP, bp);
        write_reg(tpwl_pkg::REG_EVICT_TOL, tol);
        write_reg(tpwl_pkg::REG_STALE, stale);
    endtask

    task automatic random_word(int max_gap, int tick_pct);
        int        k;
        bit [31:0] step;
        k = $urandom % 100;
        if (($urandom % 100) < tick_pct)
        begin
            if (k < 4 && cur_ts > 0)
                tick(cur_ts - $urandom_range(1, (cur_ts > 1000) ? 1000 : cur_ts), $urandom);
            else if (k < 8)
                tick(cur_ts + $urandom_range(0, max_gap), 0);
            else
            begin
                cur_ts += $urandom_range(0, max_gap);
                if (k < 14)
                    cur_px = $urandom;
                else
                begin
                    step = $urandom_range(0, cur_px / 50 + 1);
                    cur_px = ($urandom % 2) ? cur_px + step : cur_px - step;
                end
                if (cur_px == 0)
                    cur_px = 1;
                tick(cur_ts, cur_px);
            end
        end
        else if (k < 75)
            query($urandom_range(0, 40 * max_gap + 10));
        else
            query($urandom);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        query(0);
        tick(100, 1000000);
        tick(50, 5);
        tick(100, 0);
        tick(150, 1015000);
        tick(200, 1100000);
        tick(300, 1100000);
        query(0);
        query(1000);
        tick(4300, 1100000);
        query(500);
        query(4300);
        tick(4300, 1100001);
        query(0);
        query(32'hFFFFFFFF);

        cur_ts = 4300;
        cur_px = 1100001;
        set_config(32'd0, 16'd0, 14'd0, 16'd0, 16'd0);
        repeat (60) random_word(20, 70);

        set_config(32'hFFFFFFFF, 16'hFFFF, 14'd10000, 16'hFFFF, 16'hFFFF);
        repeat (1030)
        begin
            cur_ts += $urandom_range(0, 3);
            tick(cur_ts, cur_px);
        end
        repeat (60) random_word(3, 60);

        set_config(32'd600, 16'd30, 14'd200, 16'd60, 16'd40);
        cur_ts = 32'hFFFF0000;
        repeat (60) random_word(60, 70);
        tick(32'hFFFFFFFF, 32'hFFFFFFFF);
        tick(32'hFFFFFFFF, cur_px);
        query(32'hFFFFFFFF);
        query(0);

        drain();
        $display("run: %0d words sent, %0d results checked over four register settings",
                 words_sent, result_count);
        $display("run: ring fill to full, eviction, stale and jump rejects exercised");
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
